// ----- design/positional_array_list_assert.svh -----
// Assertion macros used by the checker file of this block.
`ifndef POSITIONAL_ARRAY_LIST_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PAL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/pal_pkg.sv -----
package pal_pkg;

  localparam int CAPACITY_DEF     = 64;
  localparam int ELEMENT_BITS_DEF = 32;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 6;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_EMPTY_VALUE = '0;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET    = 3'd0,
    CMD_SET    = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_WRITE,
    OP_INSERT,
    OP_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] pos;
  } cell_ctl_t;

endpackage

// ----- design/pal_cmd_if.sv -----
interface pal_cmd_if;
  import pal_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [POS_W-1:0]   position;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output command, output position, output value,
                  input ready);
  modport sink (input valid, input command, input position, input value,
                output ready);
endinterface

// ----- design/pal_res_if.sv -----
interface pal_res_if;
  import pal_pkg::*;

  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  read_value;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  count;
  logic                is_empty;

  modport source (output valid, output read_value, output status, output count,
                  output is_empty, input ready);
  modport sink (input valid, input read_value, input status, input count,
                input is_empty, output ready);
endinterface

// ----- design/pal_cell.sv -----
module pal_cell #(
  parameter int INDEX        = 0,
  parameter int ELEMENT_BITS = pal_pkg::ELEMENT_BITS_DEF
) (
  input  logic                    clk,
  input  pal_pkg::cell_ctl_t      ctl,
  input  logic [ELEMENT_BITS-1:0] din,
  input  logic [ELEMENT_BITS-1:0] left_q,
  input  logic [ELEMENT_BITS-1:0] right_q,
  output logic [ELEMENT_BITS-1:0] q,
  output logic [ELEMENT_BITS-1:0] rd
);
  import pal_pkg::*;

  logic [ELEMENT_BITS-1:0] entry_r;
  logic [ELEMENT_BITS-1:0] entry_nxt;
  logic                    hit;
  logic                    above;

  assign hit   = (int'(ctl.pos) == INDEX);
  assign above = (INDEX > int'(ctl.pos));

  always_comb begin
    entry_nxt = entry_r;
    case (ctl.op)
      OP_WRITE: begin
        if (hit) entry_nxt = din;
      end
      OP_INSERT: begin
        if (hit) entry_nxt = din;
        else if (above) entry_nxt = left_q;
      end
      OP_REMOVE: begin
        if (hit || above) entry_nxt = right_q;
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign q  = entry_r;
  // Only the addressed cell puts its entry on the shared read bus.
  assign rd = hit ? entry_r : '0;

endmodule

// ----- design/positional_array_list.sv -----
// Ordered list of up to CAPACITY entries held in a row of cells, one entry per
// cell. For each command the control compares the position with the count,
// broadcasts one operation to the row, and each cell compares its own index
// with the position to load the new value, take its left neighbor (insert),
// take its right neighbor (remove) or hold. The result item is registered and
// appears the cycle after the command is taken; a new command is taken in any
// cycle in which the result register is empty or its item is being taken, so one
// command completes per clock while the result sink keeps taking items. A get
// returns the addressed entry through an AND-OR read bus; an invalid position
// returns empty_value (register 0, byte address 0) cut to ELEMENT_BITS bits.
module positional_array_list #(
  parameter int CAPACITY     = pal_pkg::CAPACITY_DEF,
  parameter int ELEMENT_BITS = pal_pkg::ELEMENT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pal_cmd_if.sink                        in_cmd,
  pal_res_if.source                      out_res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pal_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pal_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pal_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import pal_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CFG_DATA_W-1:0]   empty_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [CNT_W-1:0]        cnt_nxt;
  logic                    out_valid_r;
  logic [VALUE_W-1:0]      out_rd_r;
  logic [VALUE_W-1:0]      out_rd_nxt;
  status_t                 out_status_r;
  status_t                 status_nxt;
  logic [COUNT_W-1:0]      out_count_r;
  logic                    out_empty_r;

  logic                    accept;
  cmd_t                    cmd;
  logic [CMP_W-1:0]        pos_c;
  logic [CMP_W-1:0]        cnt_c;
  logic                    in_range;
  logic                    ins_range;
  logic                    full;
  cell_op_t                op;
  cell_ctl_t               ctl;
  logic [ELEMENT_BITS-1:0] din;
  logic [ELEMENT_BITS-1:0] sel_word;

  logic [ELEMENT_BITS-1:0] cell_q  [CAPACITY];
  logic [ELEMENT_BITS-1:0] cell_rd [CAPACITY];

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr == REG_EMPTY_VALUE) ? empty_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_r <= '0;
    end else if (psel && penable && pwrite && paddr == REG_EMPTY_VALUE) begin
      empty_r <= pwdata;
    end
  end

  // Command decode.
  assign in_cmd.ready = rst_n && (!out_valid_r || out_res.ready);
  assign accept       = in_cmd.valid && in_cmd.ready;
  assign cmd          = cmd_t'(in_cmd.command);
  assign pos_c        = CMP_W'(in_cmd.position);
  assign cnt_c        = CMP_W'(cnt_r);
  assign in_range     = pos_c < cnt_c;
  assign ins_range    = pos_c <= cnt_c;
  assign full         = cnt_r == CNT_W'(CAPACITY);
  assign din          = ELEMENT_BITS'(in_cmd.value);

  always_comb begin
    sel_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_word = sel_word | cell_rd[i];
    end
  end

  always_comb begin
    op         = OP_HOLD;
    status_nxt = ST_DONE;
    cnt_nxt    = cnt_r;
    out_rd_nxt = '0;
    case (cmd)
      CMD_GET: begin
        if (in_range) begin
          out_rd_nxt = VALUE_W'(sel_word);
        end else begin
          out_rd_nxt = VALUE_W'(ELEMENT_BITS'(empty_r));
          status_nxt = ST_BAD_POS;
        end
      end
      CMD_SET: begin
        if (in_range) op = OP_WRITE;
        else status_nxt = ST_BAD_POS;
      end
      CMD_INSERT: begin
        if (!ins_range) begin
          status_nxt = ST_BAD_POS;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          op      = OP_INSERT;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (in_range) begin
          op      = OP_REMOVE;
          cnt_nxt = cnt_r - CNT_W'(1);
        end else begin
          status_nxt = ST_BAD_POS;
        end
      end
      CMD_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
        op = OP_HOLD;
      end
    endcase
  end

  assign ctl.op  = accept ? op : OP_HOLD;
  assign ctl.pos = in_cmd.position;

  // Row of cells; the ends see zero neighbors.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ELEMENT_BITS-1:0] left_q;
    logic [ELEMENT_BITS-1:0] right_q;

    if (g == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_mid_l
      assign left_q = cell_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_mid_r
      assign right_q = cell_q[g+1];
    end

    pal_cell #(
      .INDEX        (g),
      .ELEMENT_BITS (ELEMENT_BITS)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .din     (din),
      .left_q  (left_q),
      .right_q (right_q),
      .q       (cell_q[g]),
      .rd      (cell_rd[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_rd_r     <= out_rd_nxt;
      out_status_r <= status_nxt;
      out_count_r  <= COUNT_W'(cnt_nxt);
      out_empty_r  <= (cnt_nxt == '0);
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.read_value = out_rd_r;
  assign out_res.status     = out_status_r;
  assign out_res.count      = out_count_r;
  assign out_res.is_empty   = out_empty_r;

endmodule

// ----- design/pal_checker.sv -----
`include "positional_array_list_assert.svh"

module pal_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [pal_pkg::CMD_W-1:0]    in_command,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [pal_pkg::VALUE_W-1:0]  out_read_value,
  input logic [pal_pkg::STATUS_W-1:0] out_status,
  input logic [pal_pkg::COUNT_W-1:0]  out_count,
  input logic                         out_is_empty
);
  import pal_pkg::*;

  // A result waiting on a stalled sink stays put.
  `PAL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_read_value) && $stable(out_status) && $stable(out_count),
    "result changed while stalled")

  // Every accepted command shows its result in the next cycle.
  `PAL_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid,
    "no result after an accepted command")

  // The empty flag agrees with the count.
  `PAL_ASSERT_NOW(a_empty_flag, out_valid, out_is_empty == (out_count == '0),
    "is_empty disagrees with count")

  // A clear always succeeds and leaves the list empty.
  `PAL_ASSERT_NEXT(a_clear, in_valid && in_ready && in_command == CMD_CLEAR,
    out_status == ST_DONE && out_count == '0 && out_is_empty,
    "clear did not empty the list")

endmodule

bind positional_array_list pal_checker u_pal_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_cmd.valid),
  .in_ready       (in_cmd.ready),
  .in_command     (in_cmd.command),
  .out_valid      (out_res.valid),
  .out_ready      (out_res.ready),
  .out_read_value (out_res.read_value),
  .out_status     (out_res.status),
  .out_count      (out_res.count),
  .out_is_empty   (out_res.is_empty)
);
